// ----- sv/lns_pkg.sv -----
package lns_pkg;

    // Default build-time sizes
    localparam int DEF_MAX_SRC_W  = 256;
    localparam int DEF_MAX_SRC_H  = 256;
    localparam int DEF_COORD_BITS = 12;

    // Fixed field widths
    localparam int SRC_CFG_BITS  = 9;
    localparam int DST_BITS      = 12;
    localparam int COLOR_BITS    = 8;
    localparam int PIX_BITS      = 3 * COLOR_BITS;
    localparam int ARGB_BITS     = 32;
    localparam int SCALE_SHIFT   = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = DST_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT = 2'd3;

    // Register reset values
    localparam logic [SRC_CFG_BITS-1:0] RST_SRC_WIDTH  = 9'd1;
    localparam logic [SRC_CFG_BITS-1:0] RST_SRC_HEIGHT = 9'd1;
    localparam logic [DST_BITS-1:0]     RST_DST_WIDTH  = 12'd640;
    localparam logic [DST_BITS-1:0]     RST_DST_HEIGHT = 12'd480;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [COLOR_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic start;
        logic long_mode;
    } lns_div_ctrl_t;

endpackage

// ----- sv/lns_if.sv -----
interface lns_item_if
    import lns_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;

    modport source (output valid, kind, pos_x, pos_y, red, green, blue, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, red, green, blue, output ready);
endinterface

interface lns_result_if
    import lns_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ARGB_BITS-1:0] argb;
    logic                 inside_res;

    modport source (output valid, argb, inside_res, input ready);
    modport sink   (input valid, argb, inside_res, output ready);
endinterface

// ----- sv/lns_div.sv -----
module lns_div
    import lns_pkg::*;
#(
    parameter int DNW     = 23,
    parameter int DVW     = 12,
    parameter int K_LONG  = 20,
    parameter int K_SHORT = 8
)(
    input  logic            clk,
    input  logic            rst_n,
    input  lns_div_ctrl_t   ctrl,
    input  logic [DNW-1:0]  dividend,
    input  logic [DVW-1:0]  divisor,
    output logic            done,
    output logic [DNW-1:0]  quotient
);
    localparam int CNT_BITS = $clog2(K_LONG + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DVW-1:0]      rem_reg;
    logic [DNW-1:0]      sh_reg;
    logic [DVW-1:0]      div_reg;

    logic [DVW:0]        trial;
    logic                take;
    logic [DVW:0]        diff;
    logic [DVW-1:0]      rem_next;
    logic [DNW-1:0]      sh_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, sh_reg[DNW-1]};
        take     = (trial >= {1'b0, div_reg});
        diff     = trial - {1'b0, div_reg};
        rem_next = take ? diff[DVW-1:0] : trial[DVW-1:0];
        sh_next  = {sh_reg[DNW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctrl.long_mode ? CNT_BITS'(K_LONG) : CNT_BITS'(K_SHORT);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_BITS'(1);
            busy_reg <= (cnt_reg != CNT_BITS'(1));
            done_reg <= (cnt_reg == CNT_BITS'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Quotient length is known up front, so preload the high dividend bits
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            div_reg <= divisor;
            if (ctrl.long_mode)
            begin
                rem_reg <= DVW'(dividend >> K_LONG);
                sh_reg  <= dividend << (DNW - K_LONG);
            end
            else
            begin
                rem_reg <= DVW'(dividend >> K_SHORT);
                sh_reg  <= dividend << (DNW - K_SHORT);
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

// ----- sv/letterbox_nearest_scaler.sv -----
// Source writes are taken in idle and the block stays ready. A query outside the drawn area goes
// straight from the area check to the output. A query inside it needs two K-step divider passes
// plus a store read, K = clog2 of the larger source maximum.
// The first query after a register write first rebuilds the layout with two 20-step divider passes
// and two multiplies. One result may wait in the output.
// Reset: registers to 1, 1, 640, 480, layout cleared; the frame store is not cleared.
module letterbox_nearest_scaler
    import lns_pkg::*;
#(
    parameter int MAX_SRC_W  = DEF_MAX_SRC_W,
    parameter int MAX_SRC_H  = DEF_MAX_SRC_H,
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    lns_item_if.sink                 item,
    lns_result_if.source             result
);
    localparam int SW_BITS  = $clog2(MAX_SRC_W + 1);
    localparam int SH_BITS  = $clog2(MAX_SRC_H + 1);
    localparam int SWH_BITS = (SW_BITS > SH_BITS) ? SW_BITS : SH_BITS;
    localparam int EW       = (SWH_BITS > SRC_CFG_BITS) ? SWH_BITS : SRC_CFG_BITS;
    localparam int PB       = (COORD_BITS > DST_BITS) ? COORD_BITS : DST_BITS;
    localparam int SCW      = DST_BITS + SCALE_SHIFT;
    localparam int XB       = (MAX_SRC_W > 1) ? $clog2(MAX_SRC_W) : 1;
    localparam int YB       = (MAX_SRC_H > 1) ? $clog2(MAX_SRC_H) : 1;
    localparam int QB       = (XB > YB) ? XB : YB;
    localparam int DNW      = (SCW > DST_BITS + SWH_BITS) ? SCW : DST_BITS + SWH_BITS;
    localparam int DVW      = (DST_BITS > SWH_BITS) ? DST_BITS : SWH_BITS;
    localparam int PW       = SWH_BITS + SCW;
    localparam int CMW      = (QB > SWH_BITS) ? QB : SWH_BITS;
    localparam int DEPTH    = MAX_SRC_W * MAX_SRC_H;
    localparam int AW       = $clog2(DEPTH);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LDX   = 4'd1;
    localparam logic [3:0] ST_LWX   = 4'd2;
    localparam logic [3:0] ST_LDY   = 4'd3;
    localparam logic [3:0] ST_LWY   = 4'd4;
    localparam logic [3:0] ST_LMX   = 4'd5;
    localparam logic [3:0] ST_LCX   = 4'd6;
    localparam logic [3:0] ST_LCY   = 4'd7;
    localparam logic [3:0] ST_CHECK = 4'd8;
    localparam logic [3:0] ST_QDX   = 4'd9;
    localparam logic [3:0] ST_QWX   = 4'd10;
    localparam logic [3:0] ST_QDY   = 4'd11;
    localparam logic [3:0] ST_QWY   = 4'd12;
    localparam logic [3:0] ST_QRD   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    // Configuration and layout
    logic [SRC_CFG_BITS-1:0] src_width_reg;
    logic [SRC_CFG_BITS-1:0] src_height_reg;
    logic [DST_BITS-1:0]     dst_width_reg;
    logic [DST_BITS-1:0]     dst_height_reg;
    logic [DST_BITS-1:0]     left_reg;
    logic [DST_BITS-1:0]     top_reg;
    logic [DST_BITS-1:0]     cols_reg;
    logic [DST_BITS-1:0]     rows_reg;
    logic                    layout_valid_reg;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;

    // Work registers
    logic [COORD_BITS-1:0]   x_reg;
    logic [COORD_BITS-1:0]   y_reg;
    logic [SCW-1:0]          scx_reg;
    logic [SCW-1:0]          sc_reg;
    logic [PW-1:0]           mul_reg;
    logic [XB-1:0]           cx_reg;
    logic [YB-1:0]           cy_reg;
    logic                    inside_reg;
    logic [PIX_BITS-1:0]     rdata_reg;
    logic                    res_valid_reg;
    logic [ARGB_BITS-1:0]    argb_reg;
    logic                    inside_res_reg;

    logic [PIX_BITS-1:0]     mem [DEPTH];

    logic [EW-1:0]           sw_full;
    logic [EW-1:0]           sh_full;
    logic [SWH_BITS-1:0]     sw;
    logic [SWH_BITS-1:0]     sh;
    logic [DST_BITS-1:0]     dw;
    logic [DST_BITS-1:0]     dh;

    logic                    accept;
    logic [PB-1:0]           in_x;
    logic [PB-1:0]           in_y;
    logic                    mem_we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;

    logic [PB-1:0]           offx_full;
    logic [PB-1:0]           offy_full;
    logic                    hit;

    logic                    mul_en;
    logic [SWH_BITS-1:0]     mul_a;
    logic [SCW-1:0]          mul_b;

    lns_div_ctrl_t           div_ctrl;
    logic [DNW-1:0]          div_dividend;
    logic [DVW-1:0]          div_divisor;
    logic                    div_done;
    logic [DNW-1:0]          div_quo;

    logic [SCW-1:0]          q_sc;
    logic [CMW-1:0]          q_lim;
    logic [CMW-1:0]          q_clamped;
    logic [DST_BITS-1:0]     span_raw;
    logic [DST_BITS-1:0]     span;
    logic                    out_load;

    // Effective sizes: zero acts as one, source clamps to the store maximum
    always_comb
    begin
        if (src_width_reg == '0)
            sw_full = EW'(1);
        else if (EW'(src_width_reg) > EW'(MAX_SRC_W))
            sw_full = EW'(MAX_SRC_W);
        else
            sw_full = EW'(src_width_reg);

        if (src_height_reg == '0)
            sh_full = EW'(1);
        else if (EW'(src_height_reg) > EW'(MAX_SRC_H))
            sh_full = EW'(MAX_SRC_H);
        else
            sh_full = EW'(src_height_reg);
    end

    assign sw = sw_full[SWH_BITS-1:0];
    assign sh = sh_full[SWH_BITS-1:0];
    assign dw = (dst_width_reg == '0) ? DST_BITS'(1) : dst_width_reg;
    assign dh = (dst_height_reg == '0) ? DST_BITS'(1) : dst_height_reg;

    // Input side
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign in_x       = PB'(item.pos_x);
    assign in_y       = PB'(item.pos_y);
    assign mem_we     = accept && (item.kind == KIND_WRITE)
                        && (in_x < PB'(sw)) && (in_y < PB'(sh));
    assign waddr      = AW'(in_y[YB-1:0]) * AW'(MAX_SRC_W) + AW'(in_x[XB-1:0]);
    assign raddr      = AW'(cy_reg) * AW'(MAX_SRC_W) + AW'(cx_reg);

    // Drawn-area test
    assign offx_full = PB'(x_reg) - PB'(left_reg);
    assign offy_full = PB'(y_reg) - PB'(top_reg);
    assign hit = (PB'(x_reg) >= PB'(left_reg)) && (offx_full < PB'(cols_reg))
              && (PB'(y_reg) >= PB'(top_reg)) && (offy_full < PB'(rows_reg));

    // Shared multiplier operands
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = sw;
        mul_b  = sc_reg;
        unique case (state_reg)
            ST_LMX:
            begin
                mul_en = 1'b1;
            end
            ST_LCX:
            begin
                mul_en = 1'b1;
                mul_a  = sh;
            end
            ST_CHECK:
            begin
                mul_en = 1'b1;
                mul_b  = SCW'(offx_full[DST_BITS-1:0]);
            end
            ST_QDX:
            begin
                mul_en = 1'b1;
                mul_a  = sh;
                mul_b  = SCW'(offy_full[DST_BITS-1:0]);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Shared divider operands
    always_comb
    begin
        div_ctrl.start     = 1'b0;
        div_ctrl.long_mode = 1'b0;
        div_dividend       = mul_reg[DNW-1:0];
        div_divisor        = DVW'(cols_reg);
        unique case (state_reg)
            ST_LDX:
            begin
                div_ctrl.start     = 1'b1;
                div_ctrl.long_mode = 1'b1;
                div_dividend       = DNW'(dw) << SCALE_SHIFT;
                div_divisor        = DVW'(sw);
            end
            ST_LDY:
            begin
                div_ctrl.start     = 1'b1;
                div_ctrl.long_mode = 1'b1;
                div_dividend       = DNW'(dh) << SCALE_SHIFT;
                div_divisor        = DVW'(sh);
            end
            ST_QDX:
            begin
                div_ctrl.start = 1'b1;
            end
            ST_QDY:
            begin
                div_ctrl.start = 1'b1;
                div_divisor    = DVW'(rows_reg);
            end
            default:
            begin
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    lns_div #(
        .DNW     (DNW),
        .DVW     (DVW),
        .K_LONG  (SCW),
        .K_SHORT (QB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Quotient post-processing
    assign q_sc      = div_quo[SCW-1:0];
    assign q_lim     = (state_reg == ST_QWX) ? CMW'(sw) : CMW'(sh);
    assign q_clamped = (CMW'(div_quo[QB-1:0]) >= q_lim) ? (q_lim - CMW'(1))
                                                        : CMW'(div_quo[QB-1:0]);
    assign span_raw  = mul_reg[SCALE_SHIFT +: DST_BITS];
    assign span      = (span_raw == '0) ? DST_BITS'(1) : span_raw;

    assign out_load  = (state_reg == ST_OUT) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_QUERY))
                    state_next = layout_valid_reg ? ST_CHECK : ST_LDX;
            end
            ST_LDX:   state_next = ST_LWX;
            ST_LWX:   state_next = div_done ? ST_LDY : ST_LWX;
            ST_LDY:   state_next = ST_LWY;
            ST_LWY:   state_next = div_done ? ST_LMX : ST_LWY;
            ST_LMX:   state_next = ST_LCX;
            ST_LCX:   state_next = ST_LCY;
            ST_LCY:   state_next = ST_CHECK;
            ST_CHECK: state_next = hit ? ST_QDX : ST_OUT;
            ST_QDX:   state_next = ST_QWX;
            ST_QWX:   state_next = div_done ? ST_QDY : ST_QWX;
            ST_QDY:   state_next = ST_QWY;
            ST_QWY:   state_next = div_done ? ST_QRD : ST_QWY;
            ST_QRD:   state_next = ST_OUT;
            ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            src_width_reg    <= RST_SRC_WIDTH;
            src_height_reg   <= RST_SRC_HEIGHT;
            dst_width_reg    <= RST_DST_WIDTH;
            dst_height_reg   <= RST_DST_HEIGHT;
            layout_valid_reg <= 1'b0;
            left_reg         <= '0;
            top_reg          <= '0;
            cols_reg         <= '0;
            rows_reg         <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                layout_valid_reg <= 1'b0;
                unique case (cfg_idx)
                    REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_CFG_BITS-1:0];
                    REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_CFG_BITS-1:0];
                    REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_BITS-1:0];
                    REG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_BITS-1:0];
                    default:        layout_valid_reg <= 1'b0;
                endcase
            end
            else if (state_reg == ST_LCY)
            begin
                layout_valid_reg <= 1'b1;
            end

            // Center the drawn area on each axis
            if (state_reg == ST_LCX)
            begin
                cols_reg <= span;
                left_reg <= (dw - span) >> 1;
            end
            if (state_reg == ST_LCY)
            begin
                rows_reg <= span;
                top_reg  <= (dh - span) >> 1;
            end

            if (out_load)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= item.pos_x;
            y_reg <= item.pos_y;
        end
        if (mul_en)
            mul_reg <= PW'(mul_a) * PW'(mul_b);
        if (state_reg == ST_LWX && div_done)
            scx_reg <= q_sc;
        if (state_reg == ST_LWY && div_done)
            sc_reg <= (q_sc < scx_reg) ? q_sc : scx_reg;
        if (state_reg == ST_CHECK)
            inside_reg <= hit;
        if (state_reg == ST_QWX && div_done)
            cx_reg <= q_clamped[XB-1:0];
        if (state_reg == ST_QWY && div_done)
            cy_reg <= q_clamped[YB-1:0];
        if (out_load)
        begin
            argb_reg       <= inside_reg ? {ALPHA_OPAQUE, rdata_reg}
                                         : {ALPHA_OPAQUE, PIX_BITS'(0)};
            inside_res_reg <= inside_reg;
        end
    end

    // Frame store: write on the item transaction, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= {item.red, item.green, item.blue};
        if (state_reg == ST_QRD)
            rdata_reg <= mem[raddr];
    end

    assign result.valid      = res_valid_reg;
    assign result.argb       = argb_reg;
    assign result.inside_res = inside_res_reg;

endmodule
